/* rtl/core/lut3d_trilinear_color_map_defines.svh */
// Assertion macros for the 3D LUT color mapper.
// Included by the top level; expects clk_i and rst_ni in scope.
`ifndef LUT3D_TRILINEAR_COLOR_MAP_DEFINES_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LUT3D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LUT3D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/lut3d_pkg.sv */
// Shared types and constants for the 3D LUT color mapper.
// No dependencies; used by lut3d_round, the top level and the testbench.
`default_nettype none

package lut3d_pkg;

  localparam int GRID_MAX_DEF   = 33;
  localparam int ENTRY_BITS_DEF = 12;
  localparam int CFG_W          = 6;
  localparam int IDX_W          = 6;
  localparam int VAL_W          = 12;
  localparam int PIX_W          = 8;
  localparam int OUT_W          = 8;
  localparam logic [CFG_W-1:0] GRID_RESET = 6'd33;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [PIX_W-1:0] pixel_red;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_alpha;
    logic             last_pixel;
    logic [IDX_W-1:0] node_red_index;
    logic [IDX_W-1:0] node_green_index;
    logic [IDX_W-1:0] node_blue_index;
    logic [VAL_W-1:0] node_red_value;
    logic [VAL_W-1:0] node_green_value;
    logic [VAL_W-1:0] node_blue_value;
  } in_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] mapped_red;
    logic [OUT_W-1:0] mapped_green;
    logic [OUT_W-1:0] mapped_blue;
    logic [OUT_W-1:0] mapped_alpha;
    logic             last_out;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/lut3d_bank.sv */
// One bank of the lattice store: one write port, one registered read port.
// Standalone; instantiated eight times by the top level.
`default_nettype none

module lut3d_bank #(
  parameter int DEPTH = 4913,
  parameter int AW    = 13,
  parameter int DW    = 36
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/lut3d_round.sv */
// Pipelined divider: floor of num_i over a constant, two quotient bits per stage.
// Uses lut3d_pkg for the quotient width.
`default_nettype none

module lut3d_round #(
  parameter int      NUM_W   = 38,
  parameter longint  DIVISOR = 64'd532554750
) (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [NUM_W-1:0]              num_i,
  output logic      [lut3d_pkg::OUT_W-1:0]   q_o
);
  import lut3d_pkg::*;

  localparam int STEPS = OUT_W / 2;

  logic [NUM_W-1:0] rem_q [STEPS];
  logic [OUT_W-1:0] q_q   [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    localparam longint SH_HI = DIVISOR << (OUT_W - 1 - 2 * s);
    localparam longint SH_LO = DIVISOR << (OUT_W - 2 - 2 * s);
    logic [NUM_W-1:0] r_in, r_mid, r_out;
    logic [OUT_W-1:0] q_in;
    logic [1:0]       qb;

    if (s == 0) begin : g_first
      assign r_in = num_i;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign q_in = q_q[s-1];
    end

    always_comb begin
      qb[1] = (r_in >= NUM_W'(SH_HI));
      r_mid = qb[1] ? r_in - NUM_W'(SH_HI) : r_in;
      qb[0] = (r_mid >= NUM_W'(SH_LO));
      r_out = qb[0] ? r_mid - NUM_W'(SH_LO) : r_mid;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= r_out;
        q_q[s]   <= q_in | (OUT_W'(qb) << (OUT_W - 2 - 2 * s));
      end
    end
  end

  assign q_o = q_q[STEPS-1];

endmodule

`default_nettype wire

/* rtl/core/lut3d_trilinear_color_map.sv */
// 3D color lookup table with trilinear interpolation, pipelined top level.
// Uses lut3d_pkg, lut3d_bank, lut3d_round and the assertion macro header.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): each transfer is either a
// lattice node load or a pixel to map. A load writes one node into one of eight
// parity-banked memories at the next advancing edge and produces no result. A
// pixel produces exactly one result on the output channel (out_valid_o /
// out_stall_i / out_data_o), in order.
// Configuration: cfg_we_i writes grid_size from cfg_wdata_i; write it only while
// no item is in flight.
// Throughput is one item per clock while the output is not stalled. out_valid_o
// for a pixel rises once it has passed eleven register stages; the latency is set by
// the chain of weight multiplies, the sum tree and the four-stage rounding divider. The eight
// corner nodes are read in the same cycle since each falls in a different bank.
// Reset clears the valid bits and sets grid_size to 33; the lattice contents
// are undefined until loaded. When the receiver stalls while a result is
// waiting, the whole pipeline holds and in_stall_o rises in the same cycle;
// nothing is dropped or repeated.
`default_nettype none
`include "lut3d_trilinear_color_map_defines.svh"

module lut3d_trilinear_color_map #(
  parameter int GRID_MAX   = lut3d_pkg::GRID_MAX_DEF,
  parameter int ENTRY_BITS = lut3d_pkg::ENTRY_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lut3d_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire lut3d_pkg::in_item_t          in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output lut3d_pkg::out_item_t              out_data_o
);
  import lut3d_pkg::*;

  localparam int     NW       = $clog2(GRID_MAX + 1);
  localparam int     PW       = PIX_W + NW;
  localparam int     H        = GRID_MAX / 2 + 1;
  localparam int     DEPTH    = H * H * H;
  localparam int     AW       = $clog2(DEPTH);
  localparam int     EB       = ENTRY_BITS;
  localparam int     DW       = 3 * EB;
  localparam longint EF       = (64'd1 << ENTRY_BITS) - 64'd1;
  localparam longint ACC_MAX  = EF * 64'd16581375;
  localparam longint DEN      = EF * 64'd65025;
  localparam int     ACC_W    = $clog2(ACC_MAX + 1);
  localparam int     NUM_W    = $clog2(2 * ACC_MAX + DEN + 1);
  localparam int     PV_W     = EB + 24;
  localparam int     NSTG     = 11;

  function automatic logic [AW-1:0] node_addr(input logic [AW-1:0] hr,
                                               input logic [AW-1:0] hg,
                                               input logic [AW-1:0] hb);
    return AW'((hr * AW'(H) + hg) * AW'(H) + hb);
  endfunction

  // Half coordinate of the corner on this axis that lands in the bank of parity pbit.
  function automatic logic [AW-1:0] half_coord(input logic [NW-1:0] lo, input logic pbit);
    logic [NW-1:0] crd;
    crd = (lo[0] == pbit) ? lo : NW'(lo + 1'b1);
    return AW'(crd >> 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake and configuration
  // ---------------------------------------------------------------------------
  logic              adv;
  logic              in_acc;
  logic [NSTG:1]     v_q;
  logic [CFG_W-1:0]  grid_size_q;
  logic [NW-1:0]     n_c, nm1_c;

  assign adv        = !(v_q[NSTG] && out_stall_i);
  assign in_stall_o = !adv;
  assign in_acc     = in_valid_i && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (int'(grid_size_q) < 2) begin
      n_c = NW'(2);
    end else if (int'(grid_size_q) > GRID_MAX) begin
      n_c = NW'(GRID_MAX);
    end else begin
      n_c = NW'(grid_size_q);
    end
    nm1_c = n_c - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NSTG-1:1], in_acc && (in_data_i.kind == KIND_PIXEL)};
    end
  end

  // ---------------------------------------------------------------------------
  // Node loads go into the bank selected by the index parities. The write is
  // registered in wr_*_q so that it lands together with the corner read of a
  // pixel that entered just before the load; that pixel sees the old node.
  // ---------------------------------------------------------------------------
  logic          wr_en;
  logic [2:0]    wr_bank;
  logic [AW-1:0] wr_addr;
  logic [DW-1:0] wr_data;
  logic          wr_en_q;
  logic [2:0]    wr_bank_q;
  logic [AW-1:0] wr_addr_q;
  logic [DW-1:0] wr_data_q;

  assign wr_en = in_acc && (in_data_i.kind == KIND_LOAD)
                 && (int'(in_data_i.node_red_index) < GRID_MAX)
                 && (int'(in_data_i.node_green_index) < GRID_MAX)
                 && (int'(in_data_i.node_blue_index) < GRID_MAX);
  assign wr_bank = {in_data_i.node_red_index[0], in_data_i.node_green_index[0],
                    in_data_i.node_blue_index[0]};
  assign wr_addr = node_addr(AW'(in_data_i.node_red_index >> 1),
                             AW'(in_data_i.node_green_index >> 1),
                             AW'(in_data_i.node_blue_index >> 1));
  assign wr_data = {EB'(in_data_i.node_red_value), EB'(in_data_i.node_green_value),
                    EB'(in_data_i.node_blue_value)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q <= 1'b0;
    end else if (adv) begin
      wr_en_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      wr_bank_q <= wr_bank;
      wr_addr_q <= wr_addr;
      wr_data_q <= wr_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: channel times (n - 1).  Stage 2: base index and remainder.
  // ---------------------------------------------------------------------------
  logic [PW-1:0]    prod1_q [3];
  logic [NW-1:0]    lo2_q   [3];
  logic [PIX_W-1:0] rem2_q  [3];
  logic [2:0]       hok2_q;
  logic [PIX_W-1:0] alpha_q [NSTG:1];
  logic             last_q  [NSTG:1];
  logic [PIX_W-1:0] pix_c   [3];

  assign pix_c[0] = in_data_i.pixel_red;
  assign pix_c[1] = in_data_i.pixel_green;
  assign pix_c[2] = in_data_i.pixel_blue;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      alpha_q[1] <= in_data_i.pixel_alpha;
      last_q[1]  <= in_data_i.last_pixel;
      for (int s = 2; s <= NSTG; s++) begin
        alpha_q[s] <= alpha_q[s-1];
        last_q[s]  <= last_q[s-1];
      end
      for (int a = 0; a < 3; a++) begin
        prod1_q[a] <= PW'(pix_c[a]) * PW'(nm1_c);
      end
    end
  end

  logic [PW:0]   lo_c  [3];
  logic [PW-1:0] rem_c [3];

  // Division by 255 via (x + x/256 + 1) / 256, exact over this range.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_c[a]  = ((PW+1)'(prod1_q[a]) + (PW+1)'(prod1_q[a] >> 8) + 1'b1) >> 8;
      rem_c[a] = prod1_q[a] - ((PW'(lo_c[a]) << 8) - PW'(lo_c[a]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        lo2_q[a]  <= NW'(lo_c[a]);
        rem2_q[a] <= PIX_W'(rem_c[a]);
        hok2_q[a] <= (NW'(lo_c[a]) < nm1_c);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: bank reads, pairwise red-green weights.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] rd_addr [8];
  logic [DW-1:0] rd_data [8];

  always_comb begin
    for (int p = 0; p < 8; p++) begin
      rd_addr[p] = node_addr(half_coord(lo2_q[0], p[2]), half_coord(lo2_q[1], p[1]),
                             half_coord(lo2_q[2], p[0]));
    end
  end

  for (genvar p = 0; p < 8; p++) begin : g_bank
    lut3d_bank #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (wr_en_q && adv && (wr_bank_q == 3'(p))),
      .waddr_i (wr_addr_q),
      .wdata_i (wr_data_q),
      .re_i    (adv),
      .raddr_i (rd_addr[p]),
      .rdata_o (rd_data[p])
    );
  end

  logic [15:0]      wrg3_q [4];
  logic [PIX_W-1:0] wb3_q  [2];
  logic [2:0]       par3_q;
  logic [2:0]       hok3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 2; i++) begin
        for (int j = 0; j < 2; j++) begin
          wrg3_q[i*2+j] <= 16'(i == 1 ? rem2_q[0] : 8'd255 - rem2_q[0])
                         * 16'(j == 1 ? rem2_q[1] : 8'd255 - rem2_q[1]);
        end
      end
      wb3_q[0] <= 8'd255 - rem2_q[2];
      wb3_q[1] <= rem2_q[2];
      par3_q   <= {lo2_q[0][0], lo2_q[1][0], lo2_q[2][0]};
      hok3_q   <= hok2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: route banks to corners, full corner weights.
  // ---------------------------------------------------------------------------
  logic [DW-1:0] val4_q [8];
  logic [23:0]   w4_q   [8];
  logic [DW-1:0] corner_c [8];

  // A corner past the top of an axis has zero weight; force its value to zero.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      corner_c[c] = rd_data[{par3_q[2] ^ c[2], par3_q[1] ^ c[1], par3_q[0] ^ c[0]}];
      if ((c[2] && !hok3_q[0]) || (c[1] && !hok3_q[1]) || (c[0] && !hok3_q[2])) begin
        corner_c[c] = '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        val4_q[c] <= corner_c[c];
        w4_q[c]   <= 24'(wrg3_q[c >> 1]) * 24'(wb3_q[c & 1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: weighted values.  Stages 6 and 7: sum tree and rounding numerator.
  // ---------------------------------------------------------------------------
  logic [PV_W-1:0]  pv5_q  [24];
  logic [ACC_W-1:0] s6_q   [6];
  logic [NUM_W-1:0] num7_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int c = 0; c < 8; c++) begin
          pv5_q[ch*8+c] <= PV_W'(val4_q[c][(3-ch)*EB-1 -: EB]) * PV_W'(w4_q[c]);
        end
        for (int h = 0; h < 2; h++) begin
          s6_q[ch*2+h] <= ACC_W'(pv5_q[ch*8+h*4])   + ACC_W'(pv5_q[ch*8+h*4+1])
                        + ACC_W'(pv5_q[ch*8+h*4+2]) + ACC_W'(pv5_q[ch*8+h*4+3]);
        end
        num7_q[ch] <= ((NUM_W'(s6_q[ch*2]) + NUM_W'(s6_q[ch*2+1])) << 1) + NUM_W'(DEN);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 8 to 11: round-half-up quotient by twice the entry full scale times 255^2.
  // ---------------------------------------------------------------------------
  logic [OUT_W-1:0] q_c [3];

  for (genvar ch = 0; ch < 3; ch++) begin : g_round
    lut3d_round #(
      .NUM_W   (NUM_W),
      .DIVISOR (2 * DEN)
    ) u_round (
      .clk_i (clk_i),
      .en_i  (adv),
      .num_i (num7_q[ch]),
      .q_o   (q_c[ch])
    );
  end

  assign out_valid_o              = v_q[NSTG];
  assign out_data_o.mapped_red    = q_c[0];
  assign out_data_o.mapped_green  = q_c[1];
  assign out_data_o.mapped_blue   = q_c[2];
  assign out_data_o.mapped_alpha  = alpha_q[NSTG];
  assign out_data_o.last_out      = last_q[NSTG];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `LUT3D_ASSERT_NEXT(a_pixel_enters, in_valid_i && !in_stall_o && in_data_i.kind == KIND_PIXEL, v_q[1], "pixel transfer did not enter the pipeline")
  `LUT3D_ASSERT_NOW(a_top_rem_zero, v_q[2], (hok2_q[0] || rem2_q[0] == 8'd0) && (hok2_q[1] || rem2_q[1] == 8'd0) && (hok2_q[2] || rem2_q[2] == 8'd0), "nonzero weight at top of axis")
  `LUT3D_ASSERT_NEXT(a_stall_holds, out_valid_o && out_stall_i && v_q[NSTG-1], v_q[NSTG-1], "pipeline item lost during stall")

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking testbench for lut3d_trilinear_color_map: lattice loads, pixel mapping,
// grid_size settings and random handshake gaps. Depends on lut3d_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_top;
  import lut3d_pkg::*;

  localparam int GMAX  = GRID_MAX_DEF;
  localparam int NODES = GMAX * GMAX * GMAX;
  localparam int LATENCY = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  in_item_t         in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_item_t        out_data_o;

  lut3d_trilinear_color_map u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the lattice and the grid_size register.
  logic [VAL_W-1:0] lut_red [NODES];
  logic [VAL_W-1:0] lut_green [NODES];
  logic [VAL_W-1:0] lut_blue [NODES];
  bit               node_loaded [NODES];
  logic [CFG_W-1:0] grid_reg = GRID_RESET;

  out_item_t pending_pixels[$];
  int        fail_count = 0;
  int        pixels_checked = 0;
  int        loads_sent = 0;
  int        items_sent = 0;
  bit        no_idle = 1'b0;

  function automatic int grid_in_use();
    if (grid_reg < 2) return 2;
    if (grid_reg > GMAX) return GMAX;
    return int'(grid_reg);
  endfunction

  function automatic int node_addr(int r, int g, int b);
    return (r * GMAX + g) * GMAX + b;
  endfunction

  function automatic void axis_split(logic [PIX_W-1:0] x, output int lo, output int hi,
                                     output int rem);
    int n;
    int prod;
    n = grid_in_use();
    prod = int'(x) * (n - 1);
    lo = prod / 255;
    rem = prod % 255;
    hi = (lo + 1 < n) ? lo + 1 : lo;
  endfunction

  function automatic out_item_t interpolate_pixel(in_item_t px);
    out_item_t res;
    int r[2], g[2], b[2];
    int fr, fg, fb;
    longint unsigned wr[2], wg[2], wb[2];
    longint unsigned denom, acc, v, q;
    int a;
    axis_split(px.pixel_red, r[0], r[1], fr);
    axis_split(px.pixel_green, g[0], g[1], fg);
    axis_split(px.pixel_blue, b[0], b[1], fb);
    wr[0] = 255 - fr; wr[1] = fr;
    wg[0] = 255 - fg; wg[1] = fg;
    wb[0] = 255 - fb; wb[1] = fb;
    denom = 64'd4095 * 255 * 255 * 255;
    for (int c = 0; c < 3; c++) begin
      acc = 0;
      for (int i = 0; i < 2; i++)
        for (int j = 0; j < 2; j++)
          for (int k = 0; k < 2; k++) begin
            a = node_addr(r[i], g[j], b[k]);
            v = (c == 0) ? lut_red[a] : (c == 1) ? lut_green[a] : lut_blue[a];
            acc += v * wr[i] * wg[j] * wb[k];
          end
      if (acc > denom) acc = denom;
      q = (acc * 510 + denom) / (denom * 2);
      if (q > 255) q = 255;
      if (c == 0) res.mapped_red = q[7:0];
      else if (c == 1) res.mapped_green = q[7:0];
      else res.mapped_blue = q[7:0];
    end
    res.mapped_alpha = px.pixel_alpha;
    res.last_out = px.last_pixel;
    return res;
  endfunction

  function automatic int draw_gap();
    if (no_idle) return 0;
    return $urandom_range(0, 5);
  endfunction

  // Sends one item, waits for its transfer and updates the shadow model.
  // Valid stays high afterwards so back-to-back items need no extra edge.
  task automatic send_item(in_item_t item);
    int gap;
    int a;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    if (item.kind == KIND_PIXEL) begin
      pending_pixels.push_back(interpolate_pixel(item));
    end else if (item.node_red_index < GMAX && item.node_green_index < GMAX &&
                 item.node_blue_index < GMAX) begin
      a = node_addr(int'(item.node_red_index), int'(item.node_green_index),
                    int'(item.node_blue_index));
      lut_red[a] = item.node_red_value;
      lut_green[a] = item.node_green_value;
      lut_blue[a] = item.node_blue_value;
      node_loaded[a] = 1'b1;
      loads_sent++;
    end
  endtask

  function automatic in_item_t random_item();
    in_item_t it;
    it = ($bits(in_item_t))'({$urandom, $urandom, $urandom});
    return it;
  endfunction

  task automatic load_node(int r, int g, int b, int vr, int vg, int vb);
    in_item_t it;
    it = random_item();
    it.kind = KIND_LOAD;
    it.node_red_index = IDX_W'(r);
    it.node_green_index = IDX_W'(g);
    it.node_blue_index = IDX_W'(b);
    it.node_red_value = VAL_W'(vr);
    it.node_green_value = VAL_W'(vg);
    it.node_blue_value = VAL_W'(vb);
    send_item(it);
  endtask

  // Loads any of the eight surrounding nodes that were never written, then the pixel.
  task automatic send_pixel(logic [7:0] pr, logic [7:0] pg, logic [7:0] pb,
                            logic [7:0] pa, logic lastp);
    in_item_t it;
    int r[2], g[2], b[2];
    int rem;
    axis_split(pr, r[0], r[1], rem);
    axis_split(pg, g[0], g[1], rem);
    axis_split(pb, b[0], b[1], rem);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++)
          if (!node_loaded[node_addr(r[i], g[j], b[k])])
            load_node(r[i], g[j], b[k], $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095));
    it = random_item();
    it.kind = KIND_PIXEL;
    it.pixel_red = pr;
    it.pixel_green = pg;
    it.pixel_blue = pb;
    it.pixel_alpha = pa;
    it.last_pixel = lastp;
    send_item(it);
  endtask

  // Lets every result drain before the register may change.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    grid_reg = value;
  endtask

  // Result checker with its own random stall per transfer.
  int stall_left = 0;
  always @(posedge clk_i) begin
    out_item_t want;
    logic      stall_next;
    if (rst_ni) begin
      stall_next = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        if (pending_pixels.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data_o);
          fail_count++;
        end else begin
          want = pending_pixels.pop_front();
          pixels_checked++;
          if (out_data_o.mapped_red !== want.mapped_red)
            $display("%0t: red expected %0d actual %0d", $time, want.mapped_red,
                     out_data_o.mapped_red);
          if (out_data_o.mapped_green !== want.mapped_green)
            $display("%0t: green expected %0d actual %0d", $time, want.mapped_green,
                     out_data_o.mapped_green);
          if (out_data_o.mapped_blue !== want.mapped_blue)
            $display("%0t: blue expected %0d actual %0d", $time, want.mapped_blue,
                     out_data_o.mapped_blue);
          if (out_data_o.mapped_alpha !== want.mapped_alpha)
            $display("%0t: alpha expected %0d actual %0d", $time, want.mapped_alpha,
                     out_data_o.mapped_alpha);
          if (out_data_o.last_out !== want.last_out)
            $display("%0t: last expected %0b actual %0b", $time, want.last_out,
                     out_data_o.last_out);
          if (out_data_o !== want) fail_count++;
        end
        stall_left = draw_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        stall_next = 1'b1;
      end
      out_stall_i <= stall_next;
    end
  end

  // Default grid of 33: corners of the cube, full-scale values and passthrough fields.
  task automatic test_directed_extremes();
    load_node(0, 0, 0, 0, 4095, 0);
    load_node(GMAX - 1, GMAX - 1, GMAX - 1, 4095, 0, 4095);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
    send_pixel(8'd254, 8'd1, 8'd128, 8'hA5, 1'b0);
    send_pixel(8'd127, 8'd255, 8'd0, 8'h5A, 1'b1);
    // Indexes past the lattice are dropped; 63 sets every index bit.
    load_node(63, 0, 0, 4095, 4095, 4095);
    load_node(0, 63, 0, 4095, 4095, 4095);
    load_node(0, 0, 63, 4095, 4095, 4095);
    load_node(GMAX, GMAX, GMAX, 4095, 4095, 4095);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd1, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd2, 1'b1);
  endtask

  // Out-of-range settings clamp; nodes above the grid in use are still stored.
  task automatic test_grid_limits();
    write_grid(6'd0);
    load_node(0, 0, 0, 4095, 4095, 4095);
    load_node(1, 1, 1, 0, 0, 0);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd10, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd11, 1'b0);
    send_pixel(8'd128, 8'd64, 8'd200, 8'd12, 1'b1);
    write_grid(6'd1);
    send_pixel(8'd77, 8'd255, 8'd3, 8'd13, 1'b0);
    write_grid(6'd2);
    load_node(GMAX - 1, 0, 5, 4095, 0, 2048);
    send_pixel(8'd255, 8'd0, 8'd0, 8'd14, 1'b1);
    write_grid(6'd63);
    send_pixel(8'd255, 8'd0, 8'd40, 8'd15, 1'b0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd16, 1'b1);
  endtask

  // Mostly well-formed pixel streams with some stray loads, over several grid sizes.
  // Each grid size gets a budget of about 80 input transfers.
  task automatic test_random_stream();
    logic [CFG_W-1:0] sizes[8] = '{6'd3, 6'd33, 6'd17, 6'd2, 6'd5, 6'd1, 6'd9, 6'd63};
    in_item_t it;
    int pick;
    int stop;
    foreach (sizes[s]) begin
      write_grid(sizes[s]);
      no_idle = (s % 3 == 2);
      stop = items_sent + 80;
      while (items_sent < stop) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          it = random_item();
          it.kind = KIND_LOAD;
          send_item(it);
        end else if (pick < 20) begin
          load_node($urandom_range(0, GMAX - 1), $urandom_range(0, GMAX - 1),
                    $urandom_range(0, GMAX - 1), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095));
        end else begin
          send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                     PIX_W'($urandom), 1'($urandom));
        end
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    test_grid_limits();
    test_random_stream();
    wait_idle();
    $display("Checked %0d mapped pixels after %0d lattice loads,", pixels_checked, loads_sent);
    $display("over grid sizes 0 to 63 with random gaps and output stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout waiting for transfers");
    $display("Test completed with failures");
    $finish;
  end

endmodule

/* lut3d_trilinear_color_map.f */
+incdir+rtl/core
rtl/core/lut3d_pkg.sv
rtl/core/lut3d_bank.sv
rtl/core/lut3d_round.sv
rtl/core/lut3d_trilinear_color_map.sv
test/tb_top.sv
